/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the diameter-two check unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDTC_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdtc same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SDTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdtc next-cycle check failed");

`endif

/* src/sdtc_pkg.sv */
// ---------------------------------------------------------------------------
// Diameter-two check package
// Shared constants, flag type and pair numbering for the check unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdtc_pkg;

    localparam int unsigned ID_W           = 64;
    localparam int unsigned COUNT_W        = 4;
    localparam int unsigned MIN_CORE       = 3;
    localparam int unsigned EXTRA_VERTICES = 2;

    typedef struct packed {
        logic invalid;
        logic eligible;
    } sdtc_flags_t;

    // Position of pair (i, j), i < j, in row order over n vertices.
    function automatic int unsigned pair_index(int unsigned n, int unsigned i, int unsigned j);
        return i * n - ((i * (i + 1)) >> 1) + (j - i - 1);
    endfunction

endpackage

`default_nettype wire

/* src/sdtc_front.sv */
// ---------------------------------------------------------------------------
// Diameter-two check front end
// Classifies a record and builds the adjacency matrix over fixed slots.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdtc_front
    import sdtc_pkg::*;
#(
    parameter int unsigned MAX_CORE_VERTICES = 9,
    localparam int unsigned V    = MAX_CORE_VERTICES + EXTRA_VERTICES,
    localparam int unsigned CE_W = MAX_CORE_VERTICES * (MAX_CORE_VERTICES - 1) / 2
)
(
    input  logic [COUNT_W-1:0]           core_count,
    input  logic [CE_W-1:0]              core_edges,
    input  logic [MAX_CORE_VERTICES-1:0] common_mask,
    input  logic [MAX_CORE_VERTICES-1:0] probe_mask,
    input  logic                         probe_link,
    output sdtc_flags_t                  flags,
    output logic [V*V-1:0]               adj
);

    localparam int unsigned PC_W   = $clog2(MAX_CORE_VERTICES + 1);
    localparam int unsigned C_SLOT = MAX_CORE_VERTICES;
    localparam int unsigned P_SLOT = MAX_CORE_VERTICES + 1;

    logic [MAX_CORE_VERTICES-1:0] core_live;
    logic [PC_W-1:0]              probe_pop;
    logic [PC_W-1:0]              deg0;
    logic [PC_W-1:0]              deg1;
    logic                         invalid;
    logic                         support;

    always_comb
    begin
        for (int i = 0; i < MAX_CORE_VERTICES; i++)
        begin
            core_live[i] = (COUNT_W'(i) < core_count);
        end
    end

    always_comb
    begin
        adj = '0;
        for (int dd = MIN_CORE; dd <= MAX_CORE_VERTICES; dd++)
        begin
            if (core_count == COUNT_W'(dd))
            begin
                for (int i = 0; i < dd; i++)
                begin
                    for (int j = i + 1; j < dd; j++)
                    begin
                        adj[i * V + j] = core_edges[pair_index(dd, i, j)];
                        adj[j * V + i] = core_edges[pair_index(dd, i, j)];
                    end
                end
            end
        end
        for (int i = 0; i < MAX_CORE_VERTICES; i++)
        begin
            adj[i * V + C_SLOT] = common_mask[i] & core_live[i];
            adj[C_SLOT * V + i] = common_mask[i] & core_live[i];
            adj[i * V + P_SLOT] = probe_mask[i] & core_live[i];
            adj[P_SLOT * V + i] = probe_mask[i] & core_live[i];
        end
        adj[C_SLOT * V + P_SLOT] = probe_link;
        adj[P_SLOT * V + C_SLOT] = probe_link;
    end

    always_comb
    begin
        probe_pop = '0;
        deg0      = '0;
        deg1      = '0;
        for (int i = 0; i < MAX_CORE_VERTICES; i++)
        begin
            probe_pop = probe_pop + PC_W'(probe_mask[i]);
            deg0      = deg0 + PC_W'(adj[i]);
            deg1      = deg1 + PC_W'(adj[V + i]);
        end
    end

    always_comb
    begin
        invalid = (core_count < COUNT_W'(MIN_CORE)) ||
                  (core_count > COUNT_W'(MAX_CORE_VERTICES));
        support = (probe_mask == '0) || (probe_mask == core_live) ||
                  (COUNT_W'(probe_pop) == core_count - COUNT_W'(1)) ||
                  ((probe_pop == PC_W'(1)) && probe_link);
        flags.invalid  = invalid;
        flags.eligible = !invalid && adj[1] && (deg0 >= PC_W'(2)) && (deg1 >= PC_W'(2)) &&
                         (common_mask == core_live) && support;
    end

endmodule

`default_nettype wire

/* src/sdtc_queue.sv */
// ---------------------------------------------------------------------------
// Diameter-two check decoupling queue
// Short first-in first-out buffer between the front end and the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sdtc_queue
#(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 4,
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             wr_fire;
    logic             rd_fire;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign wr_fire = wr_en && !full;
    assign rd_fire = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(wr_fire) - CNT_W'(rd_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `SDTC_ASSERT_NEXT(a_fill_step, clk, rst_n, wr_fire && !rd_fire, count_reg == $past(count_reg) + 1'b1)
    `SDTC_ASSERT(a_no_read_when_empty, clk, rst_n, rd_en, count_reg != '0)

endmodule

`default_nettype wire

/* src/sdtc_back.sv */
// ---------------------------------------------------------------------------
// Diameter-two check back end
// Evaluates pair distances before and after the cut and packs the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sdtc_back
    import sdtc_pkg::*;
#(
    parameter int unsigned MAX_CORE_VERTICES = 9,
    localparam int unsigned V      = MAX_CORE_VERTICES + EXTRA_VERTICES,
    localparam int unsigned PAIR_W = V * (V - 1) / 2,
    localparam int unsigned LC_W   = $clog2(PAIR_W + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_take,
    input  logic [ID_W-1:0]    in_id,
    input  logic [COUNT_W-1:0] in_count,
    input  sdtc_flags_t        in_flags,
    input  logic [V*V-1:0]     in_adj,
    output logic               empty,
    input  logic               pop,
    output logic [ID_W-1:0]    result_id,
    output logic               invalid,
    output logic               eligible,
    output logic               diameter_two,
    output logic [LC_W-1:0]    lost_count,
    output logic [PAIR_W-1:0]  lost_pairs
);

    localparam int unsigned RC_W = $clog2(V);

    logic [V-1:0]       slot_live;
    logic [V*V-1:0]     adj_cut;
    logic [V*V-1:0]     near_before;
    logic [V*V-1:0]     near_after;
    logic [V*V-1:0]     lost_grid;
    logic               diam;
    logic [RC_W-1:0]    row_cnt [V];
    logic [PAIR_W-1:0]  lost_packed;
    logic [LC_W-1:0]    lost_total;
    logic               out_ready;
    logic               s1_ready;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [ID_W-1:0]    s1_id_reg;
    logic [COUNT_W-1:0] s1_count_reg;
    sdtc_flags_t        s1_flags_reg;
    logic               s1_diam_reg;
    logic [V*V-1:0]     s1_lost_reg;
    logic [RC_W-1:0]    s1_row_cnt_reg [V];

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [ID_W-1:0]    out_id_reg;
    logic               out_invalid_reg;
    logic               out_eligible_reg;
    logic               out_diam_reg;
    logic [LC_W-1:0]    out_lost_count_reg;
    logic [PAIR_W-1:0]  out_lost_pairs_reg;

    assign out_ready = !out_valid_reg || pop;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign in_take   = in_valid && s1_ready;

    always_comb
    begin
        slot_live = '1;
        for (int s = 0; s < MAX_CORE_VERTICES; s++)
        begin
            slot_live[s] = (COUNT_W'(s) < in_count);
        end
        adj_cut    = in_adj;
        adj_cut[1] = 1'b0;
        adj_cut[V] = 1'b0;
    end

    always_comb
    begin
        near_before = '0;
        near_after  = '0;
        lost_grid   = '0;
        diam        = !in_flags.invalid;
        for (int a = 0; a < V; a++)
        begin
            for (int b = a + 1; b < V; b++)
            begin
                near_before[a * V + b] = in_adj[a * V + b] |
                                         (|(in_adj[a * V +: V] & in_adj[b * V +: V]));
                near_after[a * V + b]  = adj_cut[a * V + b] |
                                         (|(adj_cut[a * V +: V] & adj_cut[b * V +: V]));
                lost_grid[a * V + b]   = near_before[a * V + b] & !near_after[a * V + b] &
                                         !in_flags.invalid;
                if (slot_live[a] && slot_live[b] && !near_before[a * V + b])
                begin
                    diam = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < V; a++)
        begin
            row_cnt[a] = '0;
            for (int b = a + 1; b < V; b++)
            begin
                row_cnt[a] = row_cnt[a] + RC_W'(lost_grid[a * V + b]);
            end
        end
    end

    always_comb
    begin
        lost_packed = '0;
        for (int dd = MIN_CORE; dd <= MAX_CORE_VERTICES; dd++)
        begin
            if (s1_count_reg == COUNT_W'(dd))
            begin
                for (int a = 0; a < V; a++)
                begin
                    for (int b = a + 1; b < V; b++)
                    begin
                        if ((a >= MAX_CORE_VERTICES || a < dd) &&
                            (b >= MAX_CORE_VERTICES || b < dd))
                        begin
                            lost_packed[pair_index(dd + EXTRA_VERTICES,
                                (a < MAX_CORE_VERTICES) ? a : a - MAX_CORE_VERTICES + dd,
                                (b < MAX_CORE_VERTICES) ? b : b - MAX_CORE_VERTICES + dd)]
                                = s1_lost_reg[a * V + b];
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        lost_total = '0;
        for (int a = 0; a < V; a++)
        begin
            lost_total = lost_total + LC_W'(s1_row_cnt_reg[a]);
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_ready ? in_valid : s1_valid_reg;
        out_valid_next = out_ready ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_id_reg      <= in_id;
            s1_count_reg   <= in_count;
            s1_flags_reg   <= in_flags;
            s1_diam_reg    <= diam;
            s1_lost_reg    <= lost_grid;
            s1_row_cnt_reg <= row_cnt;
        end
        if (out_ready && s1_valid_reg)
        begin
            out_id_reg         <= s1_id_reg;
            out_invalid_reg    <= s1_flags_reg.invalid;
            out_eligible_reg   <= s1_flags_reg.eligible;
            out_diam_reg       <= s1_diam_reg;
            out_lost_count_reg <= lost_total;
            out_lost_pairs_reg <= lost_packed;
        end
    end

    assign empty        = !out_valid_reg;
    assign result_id    = out_id_reg;
    assign invalid      = out_invalid_reg;
    assign eligible     = out_eligible_reg;
    assign diameter_two = out_diam_reg;
    assign lost_count   = out_lost_count_reg;
    assign lost_pairs   = out_lost_pairs_reg;

    `SDTC_ASSERT(a_invalid_clean, clk, rst_n, out_valid_reg && out_invalid_reg, !out_eligible_reg && !out_diam_reg && out_lost_pairs_reg == '0)
    `SDTC_ASSERT(a_count_agrees, clk, rst_n, out_valid_reg, (out_lost_count_reg == '0) == (out_lost_pairs_reg == '0))

endmodule

`default_nettype wire

/* src/small_graph_diameter_two_check_unit.sv */
// ---------------------------------------------------------------------------
// Small graph diameter-two check unit
// Checks eligibility and distance-two coverage of small graphs per record.
// ---------------------------------------------------------------------------
// Records enter through a queue-style port: a beat is taken when push is
// high and full is low. Results leave the same way: the oldest result sits
// on the result ports while empty is low and is taken when pop is high.
// Each record yields exactly one result, in arrival order.
// A front end classifies the record and builds its adjacency matrix, a
// short queue decouples it from the back end, and the back end runs two
// register stages (pair distances, then packing and population count).
// A record taken at push passes through the queue, the pair-distance
// register and the output register before its result shows. Throughput:
// one record per cycle while pop keeps the back end draining.
// Reset clears the queue and every pipeline valid bit; no result is
// pending afterward. When the receiver stalls, the result is held, the
// back end fills, the queue absorbs up to its depth and full then rises.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module small_graph_diameter_two_check_unit
    import sdtc_pkg::*;
#(
    parameter int unsigned MAX_CORE_VERTICES = 9,
    parameter int unsigned QUEUE_DEPTH       = 4,
    localparam int unsigned V      = MAX_CORE_VERTICES + EXTRA_VERTICES,
    localparam int unsigned CE_W   = MAX_CORE_VERTICES * (MAX_CORE_VERTICES - 1) / 2,
    localparam int unsigned PAIR_W = V * (V - 1) / 2,
    localparam int unsigned LC_W   = $clog2(PAIR_W + 1)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [ID_W-1:0]              record_id,
    input  logic [COUNT_W-1:0]           core_count,
    input  logic [CE_W-1:0]              core_edges,
    input  logic [MAX_CORE_VERTICES-1:0] common_mask,
    input  logic [MAX_CORE_VERTICES-1:0] probe_mask,
    input  logic                         probe_link,
    output logic                         empty,
    input  logic                         pop,
    output logic [ID_W-1:0]              result_id,
    output logic                         invalid,
    output logic                         eligible,
    output logic                         diameter_two,
    output logic [LC_W-1:0]              lost_count,
    output logic [PAIR_W-1:0]            lost_pairs
);

    localparam int unsigned ENTRY_W = ID_W + COUNT_W + $bits(sdtc_flags_t) + V * V;

    sdtc_flags_t        front_flags;
    logic [V*V-1:0]     front_adj;
    logic [ENTRY_W-1:0] q_wr_data;
    logic [ENTRY_W-1:0] q_rd_data;
    logic               q_empty;
    logic               q_take;
    logic [ID_W-1:0]    q_id;
    logic [COUNT_W-1:0] q_count;
    sdtc_flags_t        q_flags;
    logic [V*V-1:0]     q_adj;

    sdtc_front #(
        .MAX_CORE_VERTICES(MAX_CORE_VERTICES)
    ) u_front (
        .core_count (core_count),
        .core_edges (core_edges),
        .common_mask(common_mask),
        .probe_mask (probe_mask),
        .probe_link (probe_link),
        .flags      (front_flags),
        .adj        (front_adj)
    );

    assign q_wr_data = {record_id, core_count, front_flags, front_adj};

    sdtc_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push),
        .wr_data(q_wr_data),
        .full   (full),
        .rd_en  (q_take),
        .rd_data(q_rd_data),
        .empty  (q_empty)
    );

    assign {q_id, q_count, q_flags, q_adj} = q_rd_data;

    sdtc_back #(
        .MAX_CORE_VERTICES(MAX_CORE_VERTICES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (!q_empty),
        .in_take     (q_take),
        .in_id       (q_id),
        .in_count    (q_count),
        .in_flags    (q_flags),
        .in_adj      (q_adj),
        .empty       (empty),
        .pop         (pop),
        .result_id   (result_id),
        .invalid     (invalid),
        .eligible    (eligible),
        .diameter_two(diameter_two),
        .lost_count  (lost_count),
        .lost_pairs  (lost_pairs)
    );

endmodule

`default_nettype wire
